@@ hdl/kstb_pkg.sv @@
// Shared types and constants for the keysym to terminal bytes unit.
// No dependencies; compiled before the interfaces and all modules.
package kstb_pkg;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam int unsigned MAX_BYTES = 6;

    // One translated key press as handed from the front end to the byte sender.
    // byte_seq[0] is sent first; len counts bytes, 1 to MAX_BYTES.
    typedef struct packed {
        logic                        unsupported;
        logic [2:0]                  len;
        logic [MAX_BYTES-1:0][7:0]   byte_seq;
    } cmd_t;

endpackage

@@ hdl/kstb_if.sv @@
// Valid/ready channel interfaces of the keysym to terminal bytes unit:
// key items in, configuration writes in, terminal byte items out. No dependencies.
interface kstb_key_if;
    logic        valid;
    logic        ready;
    logic        key_down;
    logic [28:0] keysym;

    modport source (output valid, output key_down, output keysym, input ready);
    modport sink   (input valid, input key_down, input keysym, output ready);
endinterface

interface kstb_cfg_if;
    logic valid;
    logic ready;
    logic capture_enable;

    modport source (output valid, output capture_enable, input ready);
    modport sink   (input valid, input capture_enable, output ready);
endinterface

interface kstb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       unsupported;

    modport source (output valid, output out_byte, output last, output unsupported,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input unsupported,
                    output ready);
endinterface

@@ hdl/kstb_front.sv @@
// Front end: accepts key items, tracks modifiers, holds capture_enable and
// translates a press into a byte command. Depends on kstb_pkg and kstb_if.
module kstb_front (
    input  logic              clk,
    input  logic              rst_n,
    kstb_key_if.sink          key,
    kstb_cfg_if.sink          cfg,
    input  logic              cmd_ready,
    output logic              cmd_push,
    output kstb_pkg::cmd_t    cmd
);
    import kstb_pkg::*;

    localparam int unsigned MOD_CTRL_BIT = 1;
    localparam int unsigned MOD_ALT_BIT  = 2;

    typedef struct packed {
        logic [2:0]      len;
        logic [4:0][7:0] b;
    } seq_t;

    logic       capture_enable_reg;
    logic [4:0] mods_reg;
    logic [4:0] mods_next;
    logic [4:0] mbit;
    logic       accept;
    seq_t       seq;

    function automatic seq_t mk(logic [2:0] n, logic [7:0] b0, logic [7:0] b1,
                                logic [7:0] b2, logic [7:0] b3, logic [7:0] b4);
        seq_t s;
        s.len  = n;
        s.b[0] = b0;
        s.b[1] = b1;
        s.b[2] = b2;
        s.b[3] = b3;
        s.b[4] = b4;
        return s;
    endfunction

    function automatic logic [4:0] modifier_of(logic [28:0] k);
        logic [4:0] m;
        case (k)
            29'hFFE1, 29'hFFE2:                     m = 5'b00001;
            29'hFFE3, 29'hFFE4:                     m = 5'b00010;
            29'hFFE9:                               m = 5'b00100;
            29'hFFE7, 29'hFFE8, 29'hFFEB, 29'hFFEC: m = 5'b01000;
            29'hFFEA, 29'hFF7E, 29'hFE03:           m = 5'b10000;
            default:                                m = 5'b00000;
        endcase
        return m;
    endfunction

    // Unprefixed sequence; len 0 when the key has no mapping.
    function automatic seq_t translate(logic [28:0] k, logic ctrl);
        seq_t       s;
        logic       hit;
        logic [7:0] code;
        hit  = 1'b0;
        code = 8'h00;
        if (ctrl) begin
            hit = 1'b1;
            if (k >= 29'h41 && k <= 29'h5A) begin
                code = k[7:0] - 8'h40;
            end else if (k >= 29'h61 && k <= 29'h7A) begin
                code = k[7:0] - 8'h60;
            end else begin
                case (k)
                    29'h20:  code = 8'h00;
                    29'h5B:  code = 8'h1B;
                    29'h5C:  code = 8'h1C;
                    29'h5D:  code = 8'h1D;
                    29'h5E:  code = 8'h1E;
                    29'h5F:  code = 8'h1F;
                    29'h3F:  code = 8'h7F;
                    default: hit  = 1'b0;
                endcase
            end
        end
        if (hit) begin
            s = mk(3'd1, code, 8'h00, 8'h00, 8'h00, 8'h00);
        end else if (k >= 29'h20 && k <= 29'h7E) begin
            s = mk(3'd1, k[7:0], 8'h00, 8'h00, 8'h00, 8'h00);
        end else begin
            case (k)
                29'hFF0D: s = mk(3'd1, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFF08: s = mk(3'd1, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFF09: s = mk(3'd1, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFF1B: s = mk(3'd1, 8'h1B, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFF52: s = mk(3'd3, 8'h1B, 8'h5B, 8'h41, 8'h00, 8'h00);
                29'hFF54: s = mk(3'd3, 8'h1B, 8'h5B, 8'h42, 8'h00, 8'h00);
                29'hFF53: s = mk(3'd3, 8'h1B, 8'h5B, 8'h43, 8'h00, 8'h00);
                29'hFF51: s = mk(3'd3, 8'h1B, 8'h5B, 8'h44, 8'h00, 8'h00);
                29'hFF50: s = mk(3'd3, 8'h1B, 8'h5B, 8'h48, 8'h00, 8'h00);
                29'hFF57: s = mk(3'd3, 8'h1B, 8'h5B, 8'h46, 8'h00, 8'h00);
                29'hFF63: s = mk(3'd4, 8'h1B, 8'h5B, 8'h32, 8'h7E, 8'h00);
                29'hFFFF: s = mk(3'd4, 8'h1B, 8'h5B, 8'h33, 8'h7E, 8'h00);
                29'hFF55: s = mk(3'd4, 8'h1B, 8'h5B, 8'h35, 8'h7E, 8'h00);
                29'hFF56: s = mk(3'd4, 8'h1B, 8'h5B, 8'h36, 8'h7E, 8'h00);
                29'hFFBE: s = mk(3'd3, 8'h1B, 8'h4F, 8'h50, 8'h00, 8'h00);
                29'hFFBF: s = mk(3'd3, 8'h1B, 8'h4F, 8'h51, 8'h00, 8'h00);
                29'hFFC0: s = mk(3'd3, 8'h1B, 8'h4F, 8'h52, 8'h00, 8'h00);
                29'hFFC1: s = mk(3'd3, 8'h1B, 8'h4F, 8'h53, 8'h00, 8'h00);
                29'hFFC2: s = mk(3'd5, 8'h1B, 8'h5B, 8'h31, 8'h35, 8'h7E);
                29'hFFC3: s = mk(3'd5, 8'h1B, 8'h5B, 8'h31, 8'h37, 8'h7E);
                29'hFFC4: s = mk(3'd5, 8'h1B, 8'h5B, 8'h31, 8'h38, 8'h7E);
                29'hFFC5: s = mk(3'd5, 8'h1B, 8'h5B, 8'h31, 8'h39, 8'h7E);
                29'hFFC6: s = mk(3'd5, 8'h1B, 8'h5B, 8'h32, 8'h30, 8'h7E);
                29'hFFC7: s = mk(3'd5, 8'h1B, 8'h5B, 8'h32, 8'h31, 8'h7E);
                29'hFFC8: s = mk(3'd5, 8'h1B, 8'h5B, 8'h32, 8'h33, 8'h7E);
                29'hFFC9: s = mk(3'd5, 8'h1B, 8'h5B, 8'h32, 8'h34, 8'h7E);
                29'hFFB0: s = mk(3'd1, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB1: s = mk(3'd1, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB2: s = mk(3'd1, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB3: s = mk(3'd1, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB4: s = mk(3'd1, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB5: s = mk(3'd1, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB6: s = mk(3'd1, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB7: s = mk(3'd1, 8'h37, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB8: s = mk(3'd1, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFB9: s = mk(3'd1, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFAE: s = mk(3'd1, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFAB: s = mk(3'd1, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFAD: s = mk(3'd1, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFAA: s = mk(3'd1, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFFAF: s = mk(3'd1, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h00);
                29'hFF8D: s = mk(3'd1, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00);
                default:  s = mk(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            endcase
        end
        return s;
    endfunction

    assign key.ready = cmd_ready;
    assign cfg.ready = 1'b1;
    assign accept    = key.valid && cmd_ready;

    always_comb
    begin
        mbit      = modifier_of(key.keysym);
        mods_next = mods_reg;
        if (mbit != 5'd0) begin
            mods_next = key.key_down ? (mods_reg | mbit) : (mods_reg & ~mbit);
        end
        // translation sees the modifiers including this item's own update
        seq = translate(key.keysym, mods_next[MOD_CTRL_BIT]);

        cmd_push = accept && capture_enable_reg && key.key_down
                   && (seq.len != 3'd0 || mbit == 5'd0);

        cmd.unsupported = (seq.len == 3'd0);
        if (seq.len == 3'd0) begin
            cmd.len      = 3'd1;
            cmd.byte_seq = '0;
        end else if (mods_next[MOD_ALT_BIT]) begin
            cmd.len      = seq.len + 3'd1;
            cmd.byte_seq = {seq.b, ESC_BYTE};
        end else begin
            cmd.len      = seq.len;
            cmd.byte_seq = {8'h00, seq.b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capture_enable_reg <= 1'b1;
            mods_reg           <= 5'd0;
        end else begin
            if (cfg.valid) begin
                capture_enable_reg <= cfg.capture_enable;
            end
            if (accept) begin
                mods_reg <= mods_next;
            end
        end
    end

    a_push_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (key.key_down && capture_enable_reg && accept))
        else $error("command pushed for a release or with capture off");

endmodule

@@ hdl/kstb_queue.sv @@
// Two-entry command queue between front end and byte sender.
// Depends on kstb_pkg.
module kstb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kstb_pkg::cmd_t    push_cmd,
    output logic              push_ready,
    input  logic              pop,
    output logic              head_valid,
    output kstb_pkg::cmd_t    head_cmd
);
    import kstb_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

@@ hdl/kstb_back.sv @@
// Byte sender: walks the head command into a registered output stage, one byte per
// cycle while the receiver is ready. Depends on kstb_pkg and kstb_if.
module kstb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  kstb_pkg::cmd_t    head_cmd,
    output logic              pop,
    kstb_byte_if.source       term
);
    import kstb_pkg::*;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_unsup_reg;
    logic [2:0] idx_reg;
    logic       load;
    logic       at_end;
    logic [7:0] cur_byte;

    assign term.valid       = out_valid_reg;
    assign term.out_byte    = out_byte_reg;
    assign term.last        = out_last_reg;
    assign term.unsupported = out_unsup_reg;

    assign load     = head_valid && (!out_valid_reg || term.ready);
    assign at_end   = (idx_reg == head_cmd.len - 3'd1);
    assign cur_byte = head_cmd.byte_seq[idx_reg];
    assign pop      = load && at_end;

    always_ff @(posedge clk)
    begin
        if (load) begin
            out_byte_reg  <= cur_byte;
            out_last_reg  <= at_end;
            out_unsup_reg <= head_cmd.unsupported;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_end ? 3'd0 : idx_reg + 3'd1;
            end else if (term.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_idx_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head_cmd.len))
        else $error("byte index ran past the command length");

    a_unsup_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_unsup_reg) |-> (out_last_reg && out_byte_reg == 8'h00))
        else $error("unsupported item not a single zero byte");

    a_idx_clear_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == 3'd0))
        else $error("byte index not rewound after command");

endmodule

@@ hdl/keysym_to_terminal_bytes_unit.sv @@
// Keysym to terminal bytes: a key item is taken in any cycle the two-entry command
// queue has room; its bytes pass through the queue and the registered output stage.
// Bytes leave at one per cycle while the receiver is ready, so a press gives 1 to 6
// bytes, sent by the byte sender stepping through the command; releases and modifier
// keys give none. Reset (rst_n low, asynchronous): capture enabled, modifiers released,
// queue and output stage empty.
module keysym_to_terminal_bytes_unit (
    input  logic          clk,
    input  logic          rst_n,
    kstb_key_if.sink      key,
    kstb_cfg_if.sink      cfg,
    kstb_byte_if.source   term
);
    import kstb_pkg::*;

    logic cmd_push;
    logic cmd_ready;
    cmd_t cmd;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    kstb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key),
        .cfg       (cfg),
        .cmd_ready (cmd_ready),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    kstb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .push_ready (cmd_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    kstb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .term       (term)
    );

endmodule

@@ dv/tb_keysym_to_terminal_bytes_unit.sv @@
// Self-checking bench for keysym_to_terminal_bytes_unit: a directed table of key items, then
// random key items under several idle and stall patterns, bytes checked against a predictor.
// Depends on kstb_pkg and the kstb_key_if, kstb_cfg_if and kstb_byte_if interfaces.
module tb_keysym_to_terminal_bytes_unit;

    import kstb_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_CYCLES     = 48;

    // modifier register bits
    localparam logic [4:0] MOD_SHIFT = 5'b00001;
    localparam logic [4:0] MOD_CTRL  = 5'b00010;
    localparam logic [4:0] MOD_ALT   = 5'b00100;
    localparam logic [4:0] MOD_META  = 5'b01000;
    localparam logic [4:0] MOD_ALTGR = 5'b10000;

    localparam logic [28:0] KS_SHIFT_L     = 29'hFFE1;
    localparam logic [28:0] KS_SHIFT_R     = 29'hFFE2;
    localparam logic [28:0] KS_CTRL_L      = 29'hFFE3;
    localparam logic [28:0] KS_CTRL_R      = 29'hFFE4;
    localparam logic [28:0] KS_META_L      = 29'hFFE7;
    localparam logic [28:0] KS_META_R      = 29'hFFE8;
    localparam logic [28:0] KS_ALT_L       = 29'hFFE9;
    localparam logic [28:0] KS_ALT_R       = 29'hFFEA;
    localparam logic [28:0] KS_SUPER_L     = 29'hFFEB;
    localparam logic [28:0] KS_SUPER_R     = 29'hFFEC;
    localparam logic [28:0] KS_MODE_SWITCH = 29'hFF7E;
    localparam logic [28:0] KS_LEVEL3      = 29'hFE03;

    typedef enum logic [1:0] {ROW_PRED, ROW_TYPED, ROW_CFG} row_kind_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       unsup;
    } term_byte_t;

    // typed expectation riding along with a key item; seq holds first byte at the top
    typedef struct packed {
        logic        typed;
        logic [2:0]  n;
        logic        unsup;
        logic [47:0] seq;
    } byte_tag_t;

    // for ROW_CFG, down carries the capture_enable value
    typedef struct packed {
        row_kind_e   kind;
        logic        down;
        logic [28:0] sym;
        logic [2:0]  n;
        logic        unsup;
        logic [47:0] seq;
    } stim_row_t;

    localparam int DIR_ROWS = 28;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_TYPED, 1'b0, 29'h61,       3'd0, 1'b0, 48'h0},
        '{ROW_TYPED, 1'b1, 29'h0,        3'd0, 1'b1, 48'h0},
        '{ROW_TYPED, 1'b1, 29'h1FFFFFFF, 3'd0, 1'b1, 48'h0},
        '{ROW_TYPED, 1'b1, 29'h20,       3'd1, 1'b0, 48'h20_00_00_00_00_00},
        '{ROW_TYPED, 1'b1, 29'h7E,       3'd1, 1'b0, 48'h7E_00_00_00_00_00},
        '{ROW_TYPED, 1'b1, 29'h7F,       3'd0, 1'b1, 48'h0},
        '{ROW_TYPED, 1'b1, 29'hFFC9,     3'd5, 1'b0, 48'h1B_5B_32_34_7E_00},
        '{ROW_TYPED, 1'b1, KS_CTRL_L,    3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'h61,       3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'h3F,       3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'h20,       3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'h31,       3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'hFF52,     3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, KS_ALT_L,     3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'hFFC2,     3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'h10000041, 3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b0, KS_CTRL_R,    3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'h5B,       3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, KS_SHIFT_R,   3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, KS_SUPER_L,   3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, KS_LEVEL3,    3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'h41,       3'd0, 1'b0, 48'h0},
        '{ROW_CFG,   1'b0, 29'h0,        3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'h62,       3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b0, KS_ALT_L,     3'd0, 1'b0, 48'h0},
        '{ROW_CFG,   1'b1, 29'h0,        3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b1, 29'hFF8D,     3'd0, 1'b0, 48'h0},
        '{ROW_PRED,  1'b0, KS_MODE_SWITCH, 3'd0, 1'b0, 48'h0}
    };

    logic [28:0] modifier_keys [11] = '{
        KS_SHIFT_L, KS_SHIFT_R, KS_CTRL_L, KS_CTRL_R, KS_META_L, KS_META_R,
        KS_ALT_L, KS_ALT_R, KS_SUPER_L, KS_SUPER_R, KS_LEVEL3
    };

    logic clk = 1'b0;
    logic rst_n;

    kstb_key_if  key_if ();
    kstb_cfg_if  cfg_if ();
    kstb_byte_if byte_if ();

    keysym_to_terminal_bytes_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key_if),
        .cfg   (cfg_if),
        .term  (byte_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state, touched only by the monitor
    logic [4:0]  held_mods  = '0;
    logic        capture_on = 1'b1;
    term_byte_t  pending_bytes[$];

    byte_tag_t   typed_expect = '0;
    logic        hold_req     = 1'b0;
    int unsigned stall_pct    = 0;
    int unsigned idle_pct     = 0;

    int unsigned fail_count    = 0;
    int unsigned keys_sent     = 0;
    int unsigned cfg_writes    = 0;
    int unsigned bytes_checked = 0;
    int unsigned unsup_seen    = 0;

    function automatic void log_failure(input string msg);
        if (fail_count < 10)
            $display("ERROR: %s", msg);
        fail_count++;
    endfunction

    // Updates the held modifiers and returns the bytes a key item should give.
    function automatic void predict_press(input logic down, input logic [28:0] sym,
                                          output term_byte_t res[$]);
        logic [4:0]  mbit;
        logic [42:0] mapped;   // [42:40] length, bytes right-aligned, first byte highest
        int          len;
        res.delete();
        mapped = '0;
        case (sym)
            KS_SHIFT_L, KS_SHIFT_R:                       mbit = MOD_SHIFT;
            KS_CTRL_L, KS_CTRL_R:                         mbit = MOD_CTRL;
            KS_ALT_L:                                     mbit = MOD_ALT;
            KS_META_L, KS_META_R, KS_SUPER_L, KS_SUPER_R: mbit = MOD_META;
            KS_ALT_R, KS_MODE_SWITCH, KS_LEVEL3:          mbit = MOD_ALTGR;
            default:                                      mbit = '0;
        endcase
        held_mods = down ? (held_mods | mbit) : (held_mods & ~mbit);
        if (!capture_on || !down)
            return;

        // ctrl codes; a key outside the ctrl list falls through to the plain mapping
        if ((held_mods & MOD_CTRL) != '0)
        begin
            if (sym >= 29'h41 && sym <= 29'h5A)
                mapped = {3'd1, 32'd0, sym[7:0] - 8'h40};
            else if (sym >= 29'h61 && sym <= 29'h7A)
                mapped = {3'd1, 32'd0, sym[7:0] - 8'h60};
            else
                case (sym)
                    29'h20:  mapped = {3'd1, 40'h00};
                    29'h5B:  mapped = {3'd1, 40'h1B};
                    29'h5C:  mapped = {3'd1, 40'h1C};
                    29'h5D:  mapped = {3'd1, 40'h1D};
                    29'h5E:  mapped = {3'd1, 40'h1E};
                    29'h5F:  mapped = {3'd1, 40'h1F};
                    29'h3F:  mapped = {3'd1, 40'h7F};
                    default: mapped = '0;
                endcase
        end
        if (mapped[42:40] == 3'd0)
        begin
            if (sym >= 29'h20 && sym <= 29'h7E)
                mapped = {3'd1, 32'd0, sym[7:0]};
            else if (sym >= 29'hFFB0 && sym <= 29'hFFB9)
                mapped = {3'd1, 32'd0, 4'h3, sym[3:0]};
            else
                case (sym)
                    29'hFF0D: mapped = {3'd1, 40'h0D};
                    29'hFF08: mapped = {3'd1, 40'h08};
                    29'hFF09: mapped = {3'd1, 40'h09};
                    29'hFF1B: mapped = {3'd1, 40'h1B};
                    29'hFF52: mapped = {3'd3, 40'h1B5B41};
                    29'hFF54: mapped = {3'd3, 40'h1B5B42};
                    29'hFF53: mapped = {3'd3, 40'h1B5B43};
                    29'hFF51: mapped = {3'd3, 40'h1B5B44};
                    29'hFF50: mapped = {3'd3, 40'h1B5B48};
                    29'hFF57: mapped = {3'd3, 40'h1B5B46};
                    29'hFF63: mapped = {3'd4, 40'h1B5B327E};
                    29'hFFFF: mapped = {3'd4, 40'h1B5B337E};
                    29'hFF55: mapped = {3'd4, 40'h1B5B357E};
                    29'hFF56: mapped = {3'd4, 40'h1B5B367E};
                    29'hFFBE: mapped = {3'd3, 40'h1B4F50};
                    29'hFFBF: mapped = {3'd3, 40'h1B4F51};
                    29'hFFC0: mapped = {3'd3, 40'h1B4F52};
                    29'hFFC1: mapped = {3'd3, 40'h1B4F53};
                    29'hFFC2: mapped = {3'd5, 40'h1B5B31357E};
                    29'hFFC3: mapped = {3'd5, 40'h1B5B31377E};
                    29'hFFC4: mapped = {3'd5, 40'h1B5B31387E};
                    29'hFFC5: mapped = {3'd5, 40'h1B5B31397E};
                    29'hFFC6: mapped = {3'd5, 40'h1B5B32307E};
                    29'hFFC7: mapped = {3'd5, 40'h1B5B32317E};
                    29'hFFC8: mapped = {3'd5, 40'h1B5B32337E};
                    29'hFFC9: mapped = {3'd5, 40'h1B5B32347E};
                    29'hFFAE: mapped = {3'd1, 40'h2E};
                    29'hFFAB: mapped = {3'd1, 40'h2B};
                    29'hFFAD: mapped = {3'd1, 40'h2D};
                    29'hFFAA: mapped = {3'd1, 40'h2A};
                    29'hFFAF: mapped = {3'd1, 40'h2F};
                    29'hFF8D: mapped = {3'd1, 40'h0D};
                    default:  mapped = '0;
                endcase
        end

        len = int'(mapped[42:40]);
        if (len == 0)
        begin
            // modifier keys stay silent; anything else unmapped gets the marker
            if (mbit == '0)
                res.push_back(term_byte_t'{8'h00, 1'b1, 1'b1});
            return;
        end
        if ((held_mods & MOD_ALT) != '0)
            res.push_back(term_byte_t'{ESC_BYTE, 1'b0, 1'b0});
        for (int i = len - 1; i >= 0; i--)
            res.push_back(term_byte_t'{mapped[8*i +: 8], i == 0, 1'b0});
    endfunction

    // monitor: bytes checked first so an item accepted this edge cannot cover them
    always @(posedge clk)
    begin
        term_byte_t got;
        term_byte_t want;
        term_byte_t fresh[$];
        if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                got = term_byte_t'{byte_if.out_byte, byte_if.last, byte_if.unsupported};
                bytes_checked++;
                if (pending_bytes.size() == 0)
                    log_failure($sformatf("byte %02h last %b unsup %b with nothing due",
                                          got.data, got.last, got.unsup));
                else
                begin
                    want = pending_bytes.pop_front();
                    if (want.unsup)
                        unsup_seen++;
                    if (got.data !== want.data || got.last !== want.last
                        || got.unsup !== want.unsup)
                        log_failure($sformatf({"byte %0d: expected %02h last %b unsup %b,",
                                               " got %02h last %b unsup %b"},
                                              bytes_checked, want.data, want.last,
                                              want.unsup, got.data, got.last, got.unsup));
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                capture_on = cfg_if.capture_enable;
            if (key_if.valid && key_if.ready)
            begin
                predict_press(key_if.key_down, key_if.keysym, fresh);
                if (!typed_expect.typed)
                    foreach (fresh[i])
                        pending_bytes.push_back(fresh[i]);
                else if (typed_expect.unsup)
                    pending_bytes.push_back(term_byte_t'{8'h00, 1'b1, 1'b1});
                else
                    for (int i = 0; i < int'(typed_expect.n); i++)
                        pending_bytes.push_back(term_byte_t'{typed_expect.seq[47 - 8*i -: 8],
                                                             i == int'(typed_expect.n) - 1,
                                                             1'b0});
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        byte_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                byte_if.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                byte_if.ready <= 1'b0;
            end
            else
                byte_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles where no item moves on any channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if (!rst_n || (key_if.valid && key_if.ready) || (cfg_if.valid && cfg_if.ready)
                || (byte_if.valid && byte_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d bytes still due",
                 quiet, pending_bytes.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_key(input logic down, input logic [28:0] sym, input byte_tag_t tag);
        while ($urandom_range(99) < idle_pct)
        begin
            key_if.valid <= 1'b0;
            @(posedge clk);
        end
        key_if.valid    <= 1'b1;
        key_if.key_down <= down;
        key_if.keysym   <= sym;
        typed_expect    <= tag;
        do
            @(posedge clk);
        while (!key_if.ready);
        keys_sent++;
    endtask

    // drop key valid and wait until all due bytes are out and the block has settled
    task automatic wait_quiet();
        key_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capture(input logic en);
        wait_quiet();
        cfg_if.valid          <= 1'b1;
        cfg_if.capture_enable <= en;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_random(input int count);
        int unsigned pick;
        logic        down;
        logic [28:0] sym;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            down = 1'b1;
            if (pick < 30)
                sym = 29'($urandom_range(32'h7E, 32'h20));
            else if (pick < 40)
                sym = 29'(32'hFFBE + $urandom_range(11));      // F1-F12
            else if (pick < 48)
                sym = 29'(32'hFFAA + $urandom_range(15));      // keypad
            else if (pick < 55)
                sym = 29'(32'hFF50 + $urandom_range(7));       // cursor block
            else if (pick < 60)
                sym = 29'(32'hFF00 | $urandom_range(255));
            else if (pick < 78)
            begin
                sym  = modifier_keys[$urandom_range(10)];
                down = 1'($urandom_range(1));
            end
            else if (pick < 88)
            begin
                sym  = 29'($urandom_range(32'h7E, 32'h20));
                down = 1'b0;
            end
            else
            begin
                sym  = 29'($urandom);
                down = 1'($urandom_range(1));
            end
            send_key(down, sym, '0);
        end
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        key_if.valid          <= 1'b0;
        key_if.key_down       <= 1'b0;
        key_if.keysym         <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.capture_enable <= 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_capture(dir_rows[r].down);
            else
                send_key(dir_rows[r].down, dir_rows[r].sym,
                         byte_tag_t'{dir_rows[r].kind == ROW_TYPED, dir_rows[r].n,
                                     dir_rows[r].unsup, dir_rows[r].seq});
        end

        // long receiver hold-off while F-key presses keep coming, to back up the input
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int f = 0; f < 8; f++)
            send_key(1'b1, 29'(32'hFFC2 + f), '0);
        run_random(28);

        write_capture(1'b0);
        run_random(6);
        write_capture(1'b1);

        idle_pct = 75;
        run_random(28);

        idle_pct = 0;
        stall_pct <= 75;
        run_random(28);

        idle_pct = 20;
        stall_pct <= 20;
        run_random(28);

        wait_quiet();
        $display("Run covered %0d key items (directed table, back-pressure burst, random)",
                 keys_sent);
        $display("and %0d capture writes; %0d bytes checked, %0d unsupported markers.",
                 cfg_writes, bytes_checked, unsup_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
